// ----- rtl/hmd_pkg.sv -----
// Shared types, constants and helper functions of the hashed message deframer.
package hmd_pkg;

    // Table geometry and field widths.
    localparam int TBL_ENTRIES = 16;
    localparam int IDX_W       = 4;
    localparam int KEY_W       = 32;
    localparam int SIZE_W      = 32;
    localparam int LEN_BYTES   = 4;
    localparam int KEY_BYTES   = 4;

    // Stream port widths.
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 16;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HASH_LEN  = 2'd0;
    localparam logic [1:0] CFG_ENTRY_CNT = 2'd1;

    // Result kinds, carried on the result tuser.
    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_EMPTY    = 2'd1,
        KIND_UNKNOWN  = 2'd2,
        KIND_TOO_LONG = 2'd3
    } t_kind;

    // Operation of one queued command.
    typedef enum logic {
        OP_BYTE  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    // One classified input item as it sits in the queue.
    typedef struct packed {
        t_op                 op;
        logic [7:0]          data_byte;
        logic [IDX_W-1:0]    entry_index;
        logic [KEY_W-1:0]    entry_key;
        logic                entry_variable;
        logic [SIZE_W-1:0]   entry_size;
    } t_cmd;

    // Configuration seen by the back end.
    typedef struct packed {
        logic [2:0] hash_length;
        logic [4:0] entry_count;
    } t_cfg;

    // Status reported by the back end.
    typedef struct packed {
        logic       halted;
        logic [1:0] header_count;
    } t_status;

    // Effective hash length: zero counts as one, anything above the key width is clipped.
    function automatic logic [2:0] eff_hash_len(input logic [2:0] hl);
        logic [2:0] n;
        n = hl;
        if (n < 3'd1) begin
            n = 3'd1;
        end
        if (n > 3'(KEY_BYTES)) begin
            n = 3'(KEY_BYTES);
        end
        return n;
    endfunction

    // Mask that keeps the first n hash bytes of a key.
    function automatic logic [KEY_W-1:0] hash_mask(input logic [2:0] n);
        logic [KEY_W-1:0] m;
        case (n)
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // Replace byte position pos of a 32-bit word.
    function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] pos,
                                             input logic [7:0] b);
        logic [31:0] r;
        r = w;
        r[8*pos +: 8] = b;
        return r;
    endfunction

endpackage

// ----- rtl/hmd_front.sv -----
// Input side: accepts stream transfers, classifies them and queues them for the back end.
module hmd_front
    import hmd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic                 i_s_tuser,
    output logic                 o_q_valid,
    output t_cmd                 o_q_cmd,
    input  logic                 i_q_pop,
    output logic [1:0]           o_q_level
);

    localparam int QDEPTH = 2;

    t_cmd       r_mem [QDEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_level;
    logic       w_push;
    logic       w_pop;
    t_cmd       w_cmd;

    // Classify the item: tuser selects a table write or a stream byte.
    always_comb begin
        w_cmd.op             = i_s_tuser ? OP_WRITE : OP_BYTE;
        w_cmd.data_byte      = i_s_tdata[7:0];
        w_cmd.entry_index    = i_s_tdata[11:8];
        w_cmd.entry_key      = i_s_tdata[43:12];
        w_cmd.entry_variable = i_s_tdata[44];
        w_cmd.entry_size     = i_s_tdata[76:45];
    end

    assign o_s_tready = (r_level != 2'(QDEPTH));
    assign w_push     = i_s_tvalid && o_s_tready;
    assign w_pop      = i_q_pop && o_q_valid;
    assign o_q_valid  = (r_level != 2'd0);
    assign o_q_cmd    = r_mem[r_rd_ptr];
    assign o_q_level  = r_level;

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_level  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_level <= r_level + 2'd1;
                2'b01:   r_level <= r_level - 2'd1;
                default: r_level <= r_level;
            endcase
        end
    end

endmodule

// ----- rtl/hmd_back.sv -----
// Execution side: type table, header parsing state machine and the result register.
module hmd_back
    import hmd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_q_valid,
    input  t_cmd                 i_q_cmd,
    output logic                 o_q_pop,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output t_kind                o_m_tuser,
    output logic                 o_m_tlast,
    output t_status              o_status
);

    typedef enum logic [1:0] {
        PH_HASH    = 2'd0,
        PH_LEN     = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_HALT    = 2'd3
    } t_phase;

    // Type table, undefined until written.
    logic [KEY_W-1:0]  r_tkey  [TBL_ENTRIES];
    logic              r_tvar  [TBL_ENTRIES];
    logic [SIZE_W-1:0] r_tsize [TBL_ENTRIES];

    t_phase            r_phase, n_phase;
    logic [1:0]        r_cnt, n_cnt;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [31:0]       r_len, n_len;
    logic [SIZE_W-1:0] r_left, n_left;
    logic [IDX_W-1:0]  r_cur, n_cur;

    logic              r_out_valid;
    t_kind             r_kind, n_kind;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [7:0]        r_byte, n_byte;
    logic              r_last, n_last;
    logic              n_emit;

    logic              w_step;
    logic [2:0]        w_hlen;
    logic [KEY_W-1:0]  w_mask;
    logic [KEY_W-1:0]  w_full_key;
    logic [31:0]       w_full_len;
    logic              w_found;
    logic [IDX_W-1:0]  w_hit;

    // A command leaves the queue whenever the result register is free or being drained.
    assign o_q_pop = i_q_valid && (!r_out_valid || i_m_tready);
    assign w_step  = o_q_pop && (i_q_cmd.op == OP_BYTE);

    // Key lookup: every valid entry compared in parallel, highest index wins.
    always_comb begin
        w_hlen     = eff_hash_len(i_cfg.hash_length);
        w_mask     = hash_mask(w_hlen);
        w_full_key = put_byte(r_key, r_cnt, i_q_cmd.data_byte);
        w_full_len = put_byte(r_len, r_cnt, i_q_cmd.data_byte);
        w_found    = 1'b0;
        w_hit      = '0;
        for (int i = 0; i < TBL_ENTRIES; i++) begin
            if ((5'(i) < i_cfg.entry_count) &&
                ((r_tkey[i] & w_mask) == (w_full_key & w_mask))) begin
                w_found = 1'b1;
                w_hit   = IDX_W'(i);
            end
        end
    end

    // Next state of the message parser.
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_key   = r_key;
        n_len   = r_len;
        n_left  = r_left;
        n_cur   = r_cur;
        n_emit  = 1'b0;
        n_kind  = KIND_DATA;
        n_idx   = r_cur;
        n_byte  = 8'd0;
        n_last  = 1'b1;
        case (r_phase)
            PH_HASH: begin
                if (({1'b0, r_cnt} + 3'd1) < w_hlen) begin
                    n_cnt = r_cnt + 2'd1;
                    n_key = w_full_key;
                end else begin
                    n_cnt = 2'd0;
                    n_key = w_full_key;
                    if (!w_found) begin
                        n_phase = PH_HALT;
                        n_emit  = 1'b1;
                        n_kind  = KIND_UNKNOWN;
                        n_idx   = '0;
                    end else begin
                        n_cur = w_hit;
                        n_idx = w_hit;
                        if (r_tvar[w_hit]) begin
                            n_phase = PH_LEN;
                            n_len   = '0;
                        end else if (r_tsize[w_hit] == '0) begin
                            n_emit = 1'b1;
                            n_kind = KIND_EMPTY;
                        end else begin
                            n_left  = r_tsize[w_hit];
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
            end
            PH_LEN: begin
                n_len = w_full_len;
                if (({1'b0, r_cnt} + 3'd1) < 3'(LEN_BYTES)) begin
                    n_cnt = r_cnt + 2'd1;
                end else begin
                    n_cnt = 2'd0;
                    if (w_full_len > r_tsize[r_cur]) begin
                        n_phase = PH_HALT;
                        n_emit  = 1'b1;
                        n_kind  = KIND_TOO_LONG;
                    end else if (w_full_len == '0) begin
                        n_phase = PH_HASH;
                        n_emit  = 1'b1;
                        n_kind  = KIND_EMPTY;
                    end else begin
                        n_left  = w_full_len;
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_emit = 1'b1;
                n_kind = KIND_DATA;
                n_byte = i_q_cmd.data_byte;
                n_last = (r_left <= 32'd1);
                if (r_left <= 32'd1) begin
                    n_left  = '0;
                    n_phase = PH_HASH;
                end else begin
                    n_left = r_left - 32'd1;
                end
            end
            default: begin
                n_emit = 1'b0;
            end
        endcase
    end

    // Table writes.
    always_ff @(posedge i_clk) begin
        if (o_q_pop && (i_q_cmd.op == OP_WRITE)) begin
            r_tkey[i_q_cmd.entry_index]  <= i_q_cmd.entry_key;
            r_tvar[i_q_cmd.entry_index]  <= i_q_cmd.entry_variable;
            r_tsize[i_q_cmd.entry_index] <= i_q_cmd.entry_size;
        end
    end

    // Parser state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HASH;
            r_cnt       <= 2'd0;
            r_key       <= '0;
            r_len       <= '0;
            r_left      <= '0;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_step) begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
                r_key   <= n_key;
                r_len   <= n_len;
                r_left  <= n_left;
                r_cur   <= n_cur;
            end
            if (w_step && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_step && n_emit) begin
            r_kind <= n_kind;
            r_idx  <= n_idx;
            r_byte <= n_byte;
            r_last <= n_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_byte, r_idx};
    assign o_m_tuser  = r_kind;
    assign o_m_tlast  = r_last;

    assign o_status.halted       = (r_phase == PH_HALT);
    assign o_status.header_count = r_cnt;

endmodule

// ----- rtl/hashed_message_deframer_unit.sv -----
// Top level of the hashed message deframer: configuration registers, front and back ends.
//
// The deframer takes one input transfer per clock while its queue has room: a stream byte
// (tuser 0) or a table entry write (tuser 1). A two-entry queue separates the input side
// from the parser, and one result register holds a finished result, so a stalled output
// does not stop input until the queue is full. The parser's rate is set by the key match,
// which compares all sixteen table entries combinationally in parallel on the last hash
// byte. Each payload byte gives one result; a message with an empty payload gives one
// result of kind empty; an unknown hash or a length above the type's maximum gives one
// error result, after which stream bytes are dropped until reset (table writes are still
// taken). Configuration writes are always ready and are registered for the parser.
module hashed_message_deframer_unit
    import hmd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input stream.
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // tdata from bit 0: data_byte[7:0], entry_index[11:8], entry_key[43:12],
    // entry_variable[44], entry_size[76:45], zero fill[79:77].
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // tuser: func (0 stream byte, 1 table write).
    input  logic                 i_s_tuser,
    // Result stream.
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // tdata from bit 0: msg_index[3:0], payload_byte[11:4], zero fill[15:12].
    output logic [M_TDATA_W-1:0] o_m_tdata,
    // tuser: kind[1:0].
    output logic [1:0]           o_m_tuser,
    output logic                 o_m_tlast,
    // Configuration writes.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    logic [2:0] r_hash_len;
    logic [4:0] r_entry_cnt;
    t_cfg       w_cfg;
    logic       w_q_valid;
    t_cmd       w_q_cmd;
    logic       w_q_pop;
    logic [1:0] w_q_level;
    t_kind      w_kind;
    t_status    w_status;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_len  <= 3'd4;
            r_entry_cnt <= 5'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_HASH_LEN:  r_hash_len  <= i_cfg_data[2:0];
                CFG_ENTRY_CNT: r_entry_cnt <= i_cfg_data[4:0];
                default:       r_hash_len  <= r_hash_len;
            endcase
        end
    end

    assign w_cfg.hash_length = r_hash_len;
    assign w_cfg.entry_count = r_entry_cnt;

    hmd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_q_valid  (w_q_valid),
        .o_q_cmd    (w_q_cmd),
        .i_q_pop    (w_q_pop),
        .o_q_level  (w_q_level)
    );

    hmd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_q_valid  (w_q_valid),
        .i_q_cmd    (w_q_cmd),
        .o_q_pop    (w_q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (w_kind),
        .o_m_tlast  (o_m_tlast),
        .o_status   (w_status)
    );

    assign o_m_tuser = w_kind;

    // A pending error result means the parser has already halted.
    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (w_kind == KIND_UNKNOWN || w_kind == KIND_TOO_LONG))
            |-> w_status.halted)
        else $error("error result without halted parser");

    // The halted state holds until reset.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.halted |=> w_status.halted)
        else $error("parser left the halted state");

    // Only payload results may be non-final.
    a_nondata_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (w_kind != KIND_DATA)) |-> o_m_tlast)
        else $error("empty or error result without last");

    // The queue never overfills and input readiness follows its level.
    a_queue_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_level <= 2'd2) && (o_s_tready == (w_q_level != 2'd2)))
        else $error("queue level out of range");

endmodule

// ----- test/hashed_message_deframer_unit_tb.sv -----
// Self-checking testbench of the hashed message deframer: stream stimulus, result prediction and checks.
`timescale 1ns / 1ps

// Scoreboard: tracks the deframer's table, registers and parser state, and checks each result.
class deframe_scoreboard;

    typedef enum logic [1:0] {
        AWAIT_HASH,
        AWAIT_LENGTH,
        IN_PAYLOAD,
        HALTED
    } parse_phase_e;

    typedef struct {
        hmd_pkg::t_kind kind;
        logic [3:0]     type_idx;
        logic [7:0]     byte_val;
        logic           last;
    } frame_result_t;

    int            errors;
    logic [2:0]    hash_len;
    logic [4:0]    entry_cnt;
    logic [31:0]   type_key [hmd_pkg::TBL_ENTRIES];
    logic          type_var [hmd_pkg::TBL_ENTRIES];
    logic [31:0]   type_size [hmd_pkg::TBL_ENTRIES];
    parse_phase_e  parse_state;
    int            hdr_cnt;
    logic [31:0]   key_acc;
    logic [31:0]   len_acc;
    logic [31:0]   bytes_left;
    logic [3:0]    cur_type;
    frame_result_t awaited_results [$];

    function new();
        errors      = 0;
        hash_len    = 3'd4;
        entry_cnt   = 5'd1;
        parse_state = AWAIT_HASH;
        hdr_cnt     = 0;
        key_acc     = '0;
        len_acc     = '0;
        bytes_left  = '0;
        cur_type    = '0;
    endfunction

    function int awaiting();
        return awaited_results.size();
    endfunction

    function void set_register(logic [1:0] reg_idx, logic [7:0] data);
        if (reg_idx == hmd_pkg::CFG_HASH_LEN) begin
            hash_len = data[2:0];
        end else if (reg_idx == hmd_pkg::CFG_ENTRY_CNT) begin
            entry_cnt = data[4:0];
        end
    endfunction

    function void post(hmd_pkg::t_kind kind, logic [3:0] type_idx, logic [7:0] byte_val,
                       logic last);
        frame_result_t r;
        r.kind     = kind;
        r.type_idx = type_idx;
        r.byte_val = byte_val;
        r.last     = last;
        awaited_results.push_back(r);
    endfunction

    // A zero size closes the message at once with an empty-message result.
    function void open_payload(logic [31:0] size);
        if (size == 0) begin
            parse_state = AWAIT_HASH;
            post(hmd_pkg::KIND_EMPTY, cur_type, 8'd0, 1'b1);
        end else begin
            bytes_left  = size;
            parse_state = IN_PAYLOAD;
        end
    endfunction

    // Advance the parser by one accepted transfer and queue the result it gives, if any.
    function void take_item(hmd_pkg::t_cmd c);
        int          n;
        int          lim;
        int          cnt;
        logic [31:0] mask;
        logic        found;
        logic        last;
        if (c.op == hmd_pkg::OP_WRITE) begin
            type_key[c.entry_index]  = c.entry_key;
            type_var[c.entry_index]  = c.entry_variable;
            type_size[c.entry_index] = c.entry_size;
            return;
        end
        cnt = hdr_cnt;
        case (parse_state)
            AWAIT_HASH: begin
                n = (hash_len == 0) ? 1 : ((hash_len > hmd_pkg::KEY_BYTES) ?
                                           hmd_pkg::KEY_BYTES : int'(hash_len));
                if (cnt == 0) begin
                    key_acc = '0;
                end
                key_acc[8*cnt +: 8] = c.data_byte;
                if (cnt + 1 < n) begin
                    hdr_cnt = cnt + 1;
                    return;
                end
                hdr_cnt = 0;
                mask  = (n >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * n)) - 32'd1);
                lim   = (entry_cnt > hmd_pkg::TBL_ENTRIES) ? hmd_pkg::TBL_ENTRIES
                                                           : int'(entry_cnt);
                found = 1'b0;
                // The highest matching entry wins.
                for (int i = 0; i < lim; i++) begin
                    if (((type_key[i] ^ key_acc) & mask) == 0) begin
                        cur_type = 4'(i);
                        found    = 1'b1;
                    end
                end
                if (!found) begin
                    parse_state = HALTED;
                    post(hmd_pkg::KIND_UNKNOWN, 4'd0, 8'd0, 1'b1);
                end else if (type_var[cur_type]) begin
                    parse_state = AWAIT_LENGTH;
                    len_acc     = '0;
                end else begin
                    open_payload(type_size[cur_type]);
                end
            end
            AWAIT_LENGTH: begin
                len_acc[8*cnt +: 8] = c.data_byte;
                if (cnt + 1 < hmd_pkg::LEN_BYTES) begin
                    hdr_cnt = cnt + 1;
                    return;
                end
                hdr_cnt = 0;
                // The maximum is read only once the full length is in.
                if (len_acc > type_size[cur_type]) begin
                    parse_state = HALTED;
                    post(hmd_pkg::KIND_TOO_LONG, cur_type, 8'd0, 1'b1);
                end else begin
                    open_payload(len_acc);
                end
            end
            IN_PAYLOAD: begin
                last       = (bytes_left <= 1);
                bytes_left = last ? 32'd0 : bytes_left - 32'd1;
                if (last) begin
                    parse_state = AWAIT_HASH;
                end
                post(hmd_pkg::KIND_DATA, cur_type, c.data_byte, last);
            end
            default: begin
                // Halted: stream bytes are dropped until reset.
            end
        endcase
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
        end
    endfunction

    // Compare one result transfer with the oldest awaited result.
    function void match_result(logic [15:0] tdata, logic [1:0] tuser, logic tlast);
        frame_result_t e;
        if (awaited_results.size() == 0) begin
            $display({"%0t: result with none awaited, expected nothing, ",
                      "actual kind %0d index %0d byte %0d last %0d"},
                     $time, tuser, tdata[3:0], tdata[11:4], tlast);
            errors++;
            return;
        end
        e = awaited_results.pop_front();
        compare_field("kind", 32'(e.kind), 32'(tuser));
        compare_field("msg_index", 32'(e.type_idx), 32'(tdata[3:0]));
        compare_field("payload_byte", 32'(e.byte_val), 32'(tdata[11:4]));
        compare_field("last", 32'(e.last), 32'(tlast));
    endfunction

endclass

module hashed_message_deframer_unit_tb;
    import hmd_pkg::*;

    localparam int SETTLE_CYCLES  = 10;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int PHASE_ITEMS    = 44;
    localparam int NUM_PHASES     = 9;

    typedef enum int {
        STOP_NO_ENTRIES,
        STOP_UNKNOWN_HASH,
        STOP_TOO_LONG
    } stop_kind_e;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata   = '0;
    logic                 i_s_tuser   = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [1:0]           o_m_tuser;
    logic                 o_m_tlast;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [1:0]           i_cfg_index = '0;
    logic [7:0]           i_cfg_data  = '0;

    deframe_scoreboard sb;

    // Receiver pacing, set by the main sequence.
    int   rcv_idle_pct  = 0;
    logic hold_armed    = 1'b0;
    logic hold_done     = 1'b0;
    int   hold_left     = 0;
    int   send_idle_pct = 0;
    int   quiet_cycles  = 0;

    // Stimulus-side copy of the table and registers, used to build well-formed messages.
    logic [31:0] gen_key [TBL_ENTRIES]  = '{default: '0};
    logic        gen_var [TBL_ENTRIES]  = '{default: 1'b0};
    logic [31:0] gen_size [TBL_ENTRIES] = '{default: '0};
    int          gen_hash_n = 4;
    int          gen_lim    = 1;
    t_cmd        stim_q [$];

    int phase_hl [NUM_PHASES] = '{1, 2, 3, 4, 0, 7, 2, 4, 5};
    int phase_ec [NUM_PHASES] = '{16, 5, 31, 3, 16, 9, 1, 16, 20};

    hashed_message_deframer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Result ready: random idling, plus one long hold-off once armed.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_m_tready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (hold_armed && !hold_done && o_m_tvalid) begin
            i_m_tready <= 1'b0;
            hold_left  <= RX_HOLD_CYCLES;
            hold_done  <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // Every result transfer is checked against the oldest awaited result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.match_result(o_m_tdata, o_m_tuser, o_m_tlast);
        end
    end

    // Watchdog: ends the run after too many cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // A stream byte; the fields that only a table write uses carry noise.
    function automatic t_cmd byte_cmd(logic [7:0] b);
        t_cmd c;
        c.op             = OP_BYTE;
        c.data_byte      = b;
        c.entry_index    = 4'($urandom);
        c.entry_key      = $urandom;
        c.entry_variable = 1'($urandom);
        c.entry_size     = $urandom;
        return c;
    endfunction

    function automatic t_cmd set_entry(int idx, logic [31:0] key, logic variable,
                                       logic [31:0] size);
        t_cmd c;
        c.op             = OP_WRITE;
        c.data_byte      = 8'($urandom);
        c.entry_index    = 4'(idx);
        c.entry_key      = key;
        c.entry_variable = variable;
        c.entry_size     = size;
        gen_key[idx]     = key;
        gen_var[idx]     = variable;
        gen_size[idx]    = size;
        return c;
    endfunction

    // Random entry; half the keys share their low bytes with another entry so that
    // several entries match and the highest index must win.
    function automatic t_cmd random_entry(int idx);
        logic [31:0] key;
        logic [31:0] low_mask;
        logic        variable;
        logic [31:0] size;
        key = $urandom;
        if ($urandom_range(0, 1) == 1) begin
            low_mask = 32'hFFFF_FFFF >> (8 * $urandom_range(0, 3));
            key      = (gen_key[$urandom_range(0, TBL_ENTRIES - 1)] & low_mask) |
                       (key & ~low_mask);
        end
        variable = 1'($urandom);
        if (variable) begin
            size = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 6);
        end else begin
            size = $urandom_range(0, 5);
        end
        return set_entry(idx, key, variable, size);
    endfunction

    // Index that a hash resolves to under the current registers, or -1 if unknown.
    function automatic int resolve_type(logic [31:0] hash);
        logic [31:0] mask;
        int          w;
        mask = (gen_hash_n >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * gen_hash_n)) - 32'd1);
        w    = -1;
        for (int i = 0; i < gen_lim; i++) begin
            if (((gen_key[i] ^ hash) & mask) == 0) begin
                w = i;
            end
        end
        return w;
    endfunction

    // One well-formed message, sometimes with a table write mixed into the header
    // or into the payload.
    function automatic void queue_message();
        t_cmd        msg [$];
        t_cmd        wr;
        logic        early;
        int          w;
        int          plen;
        logic [31:0] hash;
        logic [31:0] len;
        early = ($urandom_range(0, 6) == 0);
        if (early) begin
            wr = random_entry($urandom_range(0, TBL_ENTRIES - 1));
        end
        hash = gen_key[$urandom_range(0, gen_lim - 1)];
        w    = resolve_type(hash);
        for (int i = 0; i < gen_hash_n; i++) begin
            msg.push_back(byte_cmd(hash[8*i +: 8]));
        end
        if (early) begin
            msg.insert($urandom_range(0, gen_hash_n - 1), wr);
        end
        if (gen_var[w]) begin
            if (gen_size[w] <= 8) begin
                len = ($urandom_range(0, 3) == 0) ? gen_size[w] : $urandom_range(0, gen_size[w]);
            end else begin
                len = $urandom_range(0, 8);
            end
            for (int i = 0; i < LEN_BYTES; i++) begin
                msg.push_back(byte_cmd(len[8*i +: 8]));
            end
            plen = int'(len);
        end else begin
            plen = int'(gen_size[w]);
        end
        for (int i = 0; i < plen; i++) begin
            msg.push_back(byte_cmd(8'($urandom)));
        end
        // A write after the first payload byte cannot change the message in flight.
        if (plen >= 1 && $urandom_range(0, 5) == 0) begin
            wr = random_entry($urandom_range(0, TBL_ENTRIES - 1));
            msg.insert($urandom_range(msg.size() - plen + 1, msg.size()), wr);
        end
        foreach (msg[i]) begin
            stim_q.push_back(msg[i]);
        end
    endfunction

    // Offer one item, with random gaps before it, and wait for its transfer.
    task automatic send_item(t_cmd c);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= c.op;
        i_s_tdata  <= {3'b000, c.entry_size, c.entry_variable, c.entry_key,
                       c.entry_index, c.data_byte};
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        sb.take_item(c);
    endtask

    task automatic drive_stim();
        while (stim_q.size() != 0) begin
            send_item(stim_q.pop_front());
        end
        i_s_tvalid <= 1'b0;
    endtask

    // Wait for every awaited result, then let queued items without results drain.
    task automatic settle();
        while (sb.awaiting() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [1:0] reg_idx, logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= reg_idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        sb.set_register(reg_idx, data);
        if (reg_idx == CFG_HASH_LEN) begin
            gen_hash_n = (data[2:0] == 0) ? 1 : ((data[2:0] > KEY_BYTES) ? KEY_BYTES
                                                                         : int'(data[2:0]));
        end else begin
            gen_lim = (data[4:0] > TBL_ENTRIES) ? TBL_ENTRIES : int'(data[4:0]);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] hash;
        logic [31:0] len;
        stop_kind_e  stop;
        sb = new();
        send_idle_pct = 33;
        rcv_idle_pct  = 60;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset registers: all-ones key with extreme payload
        // bytes, then a variable type with the largest maximum and a zero length, then
        // a fixed type of size zero.
        stim_q.push_back(set_entry(0, 32'hFFFF_FFFF, 1'b0, 32'd2));
        repeat (4) stim_q.push_back(byte_cmd(8'hFF));
        stim_q.push_back(byte_cmd(8'h00));
        stim_q.push_back(byte_cmd(8'hFF));
        stim_q.push_back(set_entry(0, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF));
        repeat (8) stim_q.push_back(byte_cmd(8'h00));
        stim_q.push_back(set_entry(0, 32'h0000_0000, 1'b0, 32'd0));
        repeat (4) stim_q.push_back(byte_cmd(8'h00));
        drive_stim();
        settle();

        // Random phases: register settings change between phases, pacing by thirds.
        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct = (p < 3) ? 33 : ((p < 6) ? 60 : 0);
            rcv_idle_pct  <= (p < 3) ? 60 : ((p < 6) ? 33 : 0);
            if (p == 6) begin
                hold_armed <= 1'b1;
            end
            write_register(CFG_HASH_LEN, {5'($urandom), 3'(phase_hl[p])});
            write_register(CFG_ENTRY_CNT, {3'($urandom), 5'(phase_ec[p])});
            if (p == 0) begin
                for (int i = 0; i < TBL_ENTRIES; i++) begin
                    stim_q.push_back(random_entry(i));
                end
            end
            while (stim_q.size() < PHASE_ITEMS) begin
                queue_message();
            end
            drive_stim();
            settle();
        end

        // Closing error: the block halts, so later bytes give nothing and writes are taken.
        stop = stop_kind_e'($urandom_range(0, 2));
        case (stop)
            STOP_NO_ENTRIES: begin
                write_register(CFG_ENTRY_CNT, {3'($urandom), 5'd0});
                hash = $urandom;
            end
            STOP_UNKNOWN_HASH: begin
                write_register(CFG_ENTRY_CNT, {3'($urandom), 5'd16});
                do begin
                    hash = $urandom;
                end while (resolve_type(hash) >= 0);
            end
            default: begin
                write_register(CFG_ENTRY_CNT, {3'($urandom), 5'd16});
                stim_q.push_back(set_entry(15, $urandom, 1'b1,
                                           $urandom_range(0, 32'hFFFF_0000)));
                hash = gen_key[15];
            end
        endcase
        for (int i = 0; i < gen_hash_n; i++) begin
            stim_q.push_back(byte_cmd(hash[8*i +: 8]));
        end
        if (stop == STOP_TOO_LONG) begin
            len = gen_size[15] + $urandom_range(1, 32'hFFFF);
            for (int i = 0; i < LEN_BYTES; i++) begin
                stim_q.push_back(byte_cmd(len[8*i +: 8]));
            end
        end
        repeat (3) stim_q.push_back(byte_cmd(8'($urandom)));
        stim_q.push_back(random_entry($urandom_range(0, TBL_ENTRIES - 1)));
        repeat (2) stim_q.push_back(byte_cmd(8'($urandom)));
        drive_stim();
        settle();

        if (sb.errors == 0 && sb.awaiting() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/hmd_pkg.sv
rtl/hmd_front.sv
rtl/hmd_back.sv
rtl/hashed_message_deframer_unit.sv
test/hashed_message_deframer_unit_tb.sv
